/* src/lsg3_pkg.sv */
// Shared types and constants for the 3-D least-squares gradient block.
package lsg3_pkg;

    localparam int MAX_NEIGHBORS = 27;
    localparam int CNT_W         = 5;
    localparam int ACC_OPS       = 9;   // products per neighbor
    localparam int SOLVE_OPS     = 24;  // products per solve
    localparam int STEP_W        = 5;
    localparam int NORM_BITS     = 20;  // scaled sums fit in [-2^20, 2^20)
    localparam int VAL_W         = NORM_BITS + 1;
    localparam int COF_W         = 43;
    localparam int DIV_STEPS     = 80;  // 64-bit numerator plus 16 fraction bits
    localparam int DIV_CNT_W     = 7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    localparam logic ACT_TARGET   = 1'b0;
    localparam logic ACT_NEIGHBOR = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIFF  = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_NORM0 = 8'b0000_1000,
        S_NORM  = 8'b0001_0000,
        S_SOLVE = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic              set_target;
        logic              load_in;
        logic              calc_diff;
        logic              note_overflow;
        logic              acc_mul;
        logic              solve_mul;
        logic [STEP_W-1:0] mul_idx;
        logic              bump_count;
        logic              norm_init;
        logic              norm_shift;
        logic              div_start;
        logic [1:0]        div_sel;
        logic              write_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic norm_done;
        logic det_zero;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

/* src/lsg3_div.sv */
// Bit-serial signed divider giving a saturated Q16.16 quotient.
module lsg3_div import lsg3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [79:0]          r_dvd;
    logic [64:0]          r_rem;
    logic [63:0]          r_den;
    logic [30:0]          r_q;
    logic                 r_sat;
    logic                 r_neg;

    logic [64:0] n_rem_sh;
    logic        n_ge;
    logic [63:0] n_un;
    logic [63:0] n_ud;

    always_comb begin
        n_un     = i_num[63] ? (64'd0 - i_num) : i_num;
        n_ud     = i_den[63] ? (64'd0 - i_den) : i_den;
        n_rem_sh = {r_rem[63:0], r_dvd[79]};
        n_ge     = (n_rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {n_un, 16'd0};
            r_den <= n_ud;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[78:0], 1'b0};
            r_rem <= n_ge ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            // quotient bits above bit 30 only mark saturation
            r_q   <= {r_q[29:0], n_ge};
            r_sat <= r_sat | r_q[30];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? (r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                          : (r_neg ? (32'd0 - {1'b0, r_q}) : {1'b0, r_q});

endmodule

/* src/lsg3_dp.sv */
// Datapath: offsets, normal-matrix sums, scaling, cofactor solve and output register.
module lsg3_dp import lsg3_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  logic [127:0]  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [95:0]   o_out_data,
    output logic [1:0]    o_out_user
);

    logic signed [31:0] r_tgt [4];
    logic signed [31:0] r_in  [4];
    logic signed [31:0] r_d   [4];
    logic signed [63:0] r_sum [ACC_OPS];
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [63:0]        r_all;

    logic signed [63:0]   r_prod;
    logic [STEP_W-1:0]    r_pidx;
    logic                 r_pacc;
    logic                 r_psolve;
    logic signed [63:0]   r_acc;
    logic signed [COF_W-1:0] r_cof [6];
    logic signed [63:0]   r_det;
    logic signed [63:0]   r_n   [3];
    logic signed [31:0]   r_g   [3];

    logic                 r_out_valid;
    logic [95:0]          r_out_data;
    logic [1:0]           r_out_user;

    logic signed [VAL_W-1:0] w_v [ACC_OPS];
    logic signed [31:0]      n_ma, n_mb;
    logic signed [COF_W-1:0] n_sa;
    logic signed [VAL_W-1:0] n_sb;
    logic signed [63:0]      n_acc;
    logic signed [63:0]      n_sat_sum;
    logic signed [31:0]      w_quot;
    logic                    w_div_done;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            sat_diff = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sat_diff = d[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
            sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sat_add = s;
    endfunction

    for (genvar i = 0; i < ACC_OPS; i++) begin : g_val
        assign w_v[i] = r_sum[i][VAL_W-1:0];
    end

    // neighbor product operands
    always_comb begin
        case (i_cmd.mul_idx)
            5'd0:    begin n_ma = r_d[0]; n_mb = r_d[0]; end
            5'd1:    begin n_ma = r_d[1]; n_mb = r_d[1]; end
            5'd2:    begin n_ma = r_d[2]; n_mb = r_d[2]; end
            5'd3:    begin n_ma = r_d[0]; n_mb = r_d[1]; end
            5'd4:    begin n_ma = r_d[0]; n_mb = r_d[2]; end
            5'd5:    begin n_ma = r_d[1]; n_mb = r_d[2]; end
            5'd6:    begin n_ma = r_d[3]; n_mb = r_d[0]; end
            5'd7:    begin n_ma = r_d[3]; n_mb = r_d[1]; end
            default: begin n_ma = r_d[3]; n_mb = r_d[2]; end
        endcase
    end

    // solve product operands: a=v0 b=v1 c=v2 d=v3 e=v4 f=v5, rhs v6..v8
    always_comb begin
        case (i_cmd.mul_idx)
            5'd0:    begin n_sa = COF_W'(w_v[2]); n_sb = w_v[1]; end
            5'd1:    begin n_sa = COF_W'(w_v[5]); n_sb = w_v[5]; end
            5'd2:    begin n_sa = COF_W'(w_v[4]); n_sb = w_v[5]; end
            5'd3:    begin n_sa = COF_W'(w_v[3]); n_sb = w_v[2]; end
            5'd4:    begin n_sa = COF_W'(w_v[3]); n_sb = w_v[5]; end
            5'd5:    begin n_sa = COF_W'(w_v[4]); n_sb = w_v[1]; end
            5'd6:    begin n_sa = COF_W'(w_v[0]); n_sb = w_v[2]; end
            5'd7:    begin n_sa = COF_W'(w_v[4]); n_sb = w_v[4]; end
            5'd8:    begin n_sa = COF_W'(w_v[3]); n_sb = w_v[4]; end
            5'd9:    begin n_sa = COF_W'(w_v[0]); n_sb = w_v[5]; end
            5'd10:   begin n_sa = COF_W'(w_v[0]); n_sb = w_v[1]; end
            5'd11:   begin n_sa = COF_W'(w_v[3]); n_sb = w_v[3]; end
            5'd12:   begin n_sa = r_cof[0]; n_sb = w_v[0]; end
            5'd13:   begin n_sa = r_cof[1]; n_sb = w_v[3]; end
            5'd14:   begin n_sa = r_cof[2]; n_sb = w_v[4]; end
            5'd15:   begin n_sa = r_cof[0]; n_sb = w_v[6]; end
            5'd16:   begin n_sa = r_cof[1]; n_sb = w_v[7]; end
            5'd17:   begin n_sa = r_cof[2]; n_sb = w_v[8]; end
            5'd18:   begin n_sa = r_cof[1]; n_sb = w_v[6]; end
            5'd19:   begin n_sa = r_cof[3]; n_sb = w_v[7]; end
            5'd20:   begin n_sa = r_cof[4]; n_sb = w_v[8]; end
            5'd21:   begin n_sa = r_cof[2]; n_sb = w_v[6]; end
            5'd22:   begin n_sa = r_cof[4]; n_sb = w_v[7]; end
            default: begin n_sa = r_cof[5]; n_sb = w_v[8]; end
        endcase
    end

    // accumulate the registered solve product
    always_comb begin
        case (r_pidx)
            5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15, 5'd18, 5'd21:
                n_acc = r_prod;
            5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11:
                n_acc = r_acc - r_prod;
            default:
                n_acc = r_acc + r_prod;
        endcase
        n_sat_sum = sat_add(r_sum[r_pidx[3:0]], r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_mul)
            r_prod <= n_ma * n_mb;
        else
            r_prod <= n_sa * n_sb;
        r_pidx <= i_cmd.mul_idx;
        if (i_cmd.load_in) begin
            for (int i = 0; i < 4; i++)
                r_in[i] <= i_in_data[32*i +: 32];
        end
        if (i_cmd.calc_diff) begin
            for (int i = 0; i < 4; i++)
                r_d[i] <= sat_diff(r_in[i], r_tgt[i]);
        end
        if (r_psolve) begin
            r_acc <= n_acc;
            case (r_pidx)
                5'd1:    r_cof[0] <= n_acc[COF_W-1:0];
                5'd3:    r_cof[1] <= n_acc[COF_W-1:0];
                5'd5:    r_cof[2] <= n_acc[COF_W-1:0];
                5'd7:    r_cof[3] <= n_acc[COF_W-1:0];
                5'd9:    r_cof[4] <= n_acc[COF_W-1:0];
                5'd11:   r_cof[5] <= n_acc[COF_W-1:0];
                5'd14:   r_det    <= n_acc;
                5'd17:   r_n[0]   <= n_acc;
                5'd20:   r_n[1]   <= n_acc;
                5'd23:   r_n[2]   <= n_acc;
                default: ;
            endcase
        end
        if (w_div_done)
            r_g[i_cmd.div_sel] <= w_quot;
        if (i_cmd.norm_init) begin
            r_all <= (r_sum[0][63] ? ~r_sum[0] : r_sum[0]) | (r_sum[1][63] ? ~r_sum[1] : r_sum[1])
                   | (r_sum[2][63] ? ~r_sum[2] : r_sum[2]) | (r_sum[3][63] ? ~r_sum[3] : r_sum[3])
                   | (r_sum[4][63] ? ~r_sum[4] : r_sum[4]) | (r_sum[5][63] ? ~r_sum[5] : r_sum[5])
                   | (r_sum[6][63] ? ~r_sum[6] : r_sum[6]) | (r_sum[7][63] ? ~r_sum[7] : r_sum[7])
                   | (r_sum[8][63] ? ~r_sum[8] : r_sum[8]);
        end else if (i_cmd.norm_shift) begin
            r_all <= {1'b0, r_all[63:1]};
        end
        if (i_cmd.write_out) begin
            r_out_data <= (r_det == 64'sd0) ? 96'd0 : {r_g[2], r_g[1], r_g[0]};
            r_out_user <= (r_det == 64'sd0) ? ST_SINGULAR : (r_ovf ? ST_DROPPED : ST_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++)
                r_tgt[i] <= '0;
            for (int i = 0; i < ACC_OPS; i++)
                r_sum[i] <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pacc      <= 1'b0;
            r_psolve    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pacc   <= i_cmd.acc_mul;
            r_psolve <= i_cmd.solve_mul;
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            if (i_cmd.write_out)
                r_out_valid <= 1'b1;
            if (i_cmd.set_target || i_cmd.write_out) begin
                for (int i = 0; i < ACC_OPS; i++)
                    r_sum[i] <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (r_pacc)
                    r_sum[r_pidx[3:0]] <= n_sat_sum;
                if (i_cmd.norm_shift) begin
                    for (int i = 0; i < ACC_OPS; i++)
                        r_sum[i] <= {r_sum[i][63], r_sum[i][63:1]};
                end
                if (i_cmd.bump_count)
                    r_count <= r_count + 1'b1;
                if (i_cmd.note_overflow)
                    r_ovf <= 1'b1;
            end
            if (i_cmd.set_target) begin
                for (int i = 0; i < 4; i++)
                    r_tgt[i] <= i_in_data[32*i +: 32];
            end
        end
    end

    lsg3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_n[i_cmd.div_sel]),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.full      = (r_count == CNT_W'(MAX_NEIGHBORS));
    assign o_stat.norm_done = (r_all[63:NORM_BITS] == '0);
    assign o_stat.det_zero  = (r_det == 64'sd0);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_busy  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NEIGHBORS))
        else $error("neighbor count past bound");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_out |-> !r_out_valid)
        else $error("result written over a pending result");

    a_shift_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.norm_shift |-> !o_stat.norm_done)
        else $error("scaling shift issued when sums already fit");

endmodule

/* src/lsg3_ctrl.sv */
// Controller: sequences accumulation, scaling, cofactor products and divisions.
module lsg3_ctrl import lsg3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_action,
    input  logic  i_in_last,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_k, n_k;
    logic              r_div_busy, n_div_busy;
    logic              r_last, n_last;
    logic              w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_k        = r_k;
        n_div_busy = r_div_busy;
        n_last     = r_last;
        o_cmd      = '0;
        o_cmd.mul_idx = r_step;
        o_cmd.div_sel = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_action == ACT_TARGET) begin
                        o_cmd.set_target = 1'b1;
                    end else begin
                        o_cmd.load_in = 1'b1;
                        n_last        = i_in_last;
                        n_state       = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_step = '0;
                if (i_stat.full) begin
                    // drop the neighbor, still solve on last
                    o_cmd.note_overflow = 1'b1;
                    n_state = r_last ? S_NORM0 : S_IDLE;
                end else begin
                    o_cmd.calc_diff = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_step < STEP_W'(ACC_OPS))
                    o_cmd.acc_mul = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(ACC_OPS)) begin
                    o_cmd.bump_count = 1'b1;
                    n_state = r_last ? S_NORM0 : S_IDLE;
                end
            end
            S_NORM0: begin
                o_cmd.norm_init = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                n_step = '0;
                if (i_stat.norm_done)
                    n_state = S_SOLVE;
                else
                    o_cmd.norm_shift = 1'b1;
            end
            S_SOLVE: begin
                if (r_step < STEP_W'(SOLVE_OPS))
                    o_cmd.solve_mul = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(SOLVE_OPS)) begin
                    n_k        = '0;
                    n_div_busy = 1'b0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.det_zero) begin
                    n_state = S_DONE;
                end else if (!r_div_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_div_busy = 1'b1;
                end else if (i_stat.div_done) begin
                    n_div_busy = 1'b0;
                    if (r_k == 2'd2)
                        n_state = S_DONE;
                    else
                        n_k = r_k + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the previous result has been taken
                if (!i_stat.out_busy) begin
                    o_cmd.write_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_k        <= '0;
            r_div_busy <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_k        <= n_k;
            r_div_busy <= n_div_busy;
            r_last     <= n_last;
        end
    end

    a_step_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc_mul |-> (r_step < STEP_W'(ACC_OPS)))
        else $error("accumulate step out of range");

    a_div_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (r_k <= 2'd2) && !i_stat.det_zero)
        else $error("division started with bad component or zero determinant");

    a_one_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.acc_mul && o_cmd.solve_mul))
        else $error("two multiplier users in one cycle");

endmodule

/* src/least_squares_gradient_3d.sv */
// Top level of the 3-D least-squares gradient block.
// A set-target transfer (tuser 0) clears the sums. A neighbor transfer (tuser 1)
// computes offsets, then nine Q32.32 products through one 32x32 multiplier with
// saturating accumulation; a neighbor beyond 27 is dropped. A neighbor with tlast
// also runs the solve: one-bit common scaling of the sums, cofactor, determinant
// and numerator products through one 43x21 multiplier, and three bit-serial
// divisions. The input accepts the next transfer once the solve has written its
// result, even while that result still waits on the output side.
module least_squares_gradient_3d import lsg3_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // coord_x, coord_y, coord_z, value
    input  logic         s_axis_tuser,   // action
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // grad_x, grad_y, grad_z
    output logic [1:0]   m_axis_tuser    // status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lsg3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lsg3_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

/* test/least_squares_gradient_3d_tb.sv */
// Testbench for the 3-D least-squares gradient block: predicted gradients checked per transfer.
`timescale 1ns / 100ps

module least_squares_gradient_3d_tb;
    import lsg3_pkg::*;

    typedef struct packed {
        logic        action;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] val;
        logic        last;
    } t_cell;

    typedef struct packed {
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic [1:0]  status;
    } t_grad;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // coord_x, coord_y, coord_z, value
    logic         s_axis_tuser;   // action
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // grad_x, grad_y, grad_z
    logic [1:0]   m_axis_tuser;   // status

    least_squares_gradient_3d DUT (.*);

    // predictor state
    longint tgt_x, tgt_y, tgt_z, tgt_v;
    longint acc[9];   // xx yy zz xy xz yz, rhs x y z
    int     nbr_cnt;
    bit     dropped;

    t_cell  cell_q[$];
    t_grad  grad_q[$];
    int     errors;
    int     n_sent, n_grads, n_singular, n_dropped;
    int     send_idle, recv_stall;
    bit     hold_send;
    logic   s_axis_tready_q;

    always #5 i_clk = ~i_clk;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
        return s;
    endfunction

    function automatic longint q16_div(longint n, longint d);
        logic [63:0] un, ud, q, r, m;
        bit          neg;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        q   = un / ud;
        r   = un % ud;
        if (q > 64'h7FFF) return neg ? -64'sd2147483648 : 64'sd2147483647;
        m = q << 16;
        for (int i = 15; i >= 0; i--) begin
            r = r << 1;
            if (r >= ud) begin
                r = r - ud;
                m[i] = 1'b1;
            end
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic void clear_sums();
        foreach (acc[i]) acc[i] = 0;
        nbr_cnt = 0;
        dropped = 0;
    endfunction

    // Advance the gradient predictor by one cell; push a result on the last neighbor.
    function automatic void predict_gradient(t_cell c);
        longint dx, dy, dz, dv, a, b, cc, d, e, f;
        longint c00, c01, c02, c11, c12, c22, det;
        longint v[9];
        logic [63:0] all;
        int     sh;
        t_grad  g;
        if (c.action == ACT_TARGET) begin
            tgt_x = longint'(signed'(c.cx));
            tgt_y = longint'(signed'(c.cy));
            tgt_z = longint'(signed'(c.cz));
            tgt_v = longint'(signed'(c.val));
            clear_sums();
            return;
        end
        if (nbr_cnt < MAX_NEIGHBORS) begin
            dx = sat32(longint'(signed'(c.cx)) - tgt_x);
            dy = sat32(longint'(signed'(c.cy)) - tgt_y);
            dz = sat32(longint'(signed'(c.cz)) - tgt_z);
            dv = sat32(longint'(signed'(c.val)) - tgt_v);
            acc[0] = sat_add(acc[0], dx * dx);
            acc[1] = sat_add(acc[1], dy * dy);
            acc[2] = sat_add(acc[2], dz * dz);
            acc[3] = sat_add(acc[3], dx * dy);
            acc[4] = sat_add(acc[4], dx * dz);
            acc[5] = sat_add(acc[5], dy * dz);
            acc[6] = sat_add(acc[6], dv * dx);
            acc[7] = sat_add(acc[7], dv * dy);
            acc[8] = sat_add(acc[8], dv * dz);
            nbr_cnt++;
        end else begin
            dropped = 1;
        end
        if (!c.last) return;
        all = 0;
        foreach (acc[i]) all |= (acc[i] < 0) ? ~acc[i] : acc[i];
        sh = 0;
        while ((all >> sh) >= 64'd1 << NORM_BITS) sh++;
        foreach (acc[i]) v[i] = acc[i] >>> sh;
        a = v[0]; b = v[1]; cc = v[2]; d = v[3]; e = v[4]; f = v[5];
        c00 = b * cc - f * f;
        c01 = e * f - d * cc;
        c02 = d * f - e * b;
        c11 = a * cc - e * e;
        c12 = d * e - a * f;
        c22 = a * b - d * d;
        det = a * c00 + d * c01 + e * c02;
        g = '0;
        if (det == 0) begin
            g.status = ST_SINGULAR;
            n_singular++;
        end else begin
            g.gx = 32'(q16_div(c00 * v[6] + c01 * v[7] + c02 * v[8], det));
            g.gy = 32'(q16_div(c01 * v[6] + c11 * v[7] + c12 * v[8], det));
            g.gz = 32'(q16_div(c02 * v[6] + c12 * v[7] + c22 * v[8], det));
            g.status = dropped ? ST_DROPPED : ST_OK;
            if (dropped) n_dropped++;
        end
        grad_q.push_back(g);
        clear_sums();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2048)) - 1024) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cell mk(logic act, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, logic [31:0] v, logic lst);
        t_cell c;
        c.action = act; c.cx = x; c.cy = y; c.cz = z; c.val = v; c.last = lst;
        return c;
    endfunction

    // Moderate coordinates near the target keep most solves well conditioned.
    function automatic logic [31:0] near_word();
        return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_cell c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (cell_q.size() > 0 && !hold_send && $urandom_range(1, 100) > send_idle) begin
                    c = cell_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= c.action;
                    s_axis_tdata  <= {c.val, c.cz, c.cy, c.cx};
                    s_axis_tlast  <= c.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(1, 100) > recv_stall);
        end
    end

    // track acceptance at the rising edge so the driver knows the item was taken
    always @(posedge i_clk) begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            n_sent++;
            predict_gradient(mk(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                                s_axis_tdata[95:64], s_axis_tdata[127:96], s_axis_tlast));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grad g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_grads++;
            if (grad_q.size() == 0) begin
                report_mismatch("unexpected gradient", m_axis_tdata[31:0], '0);
            end else begin
                g = grad_q.pop_front();
                if (m_axis_tdata[31:0] !== g.gx)
                    report_mismatch("grad_x", m_axis_tdata[31:0], g.gx);
                if (m_axis_tdata[63:32] !== g.gy)
                    report_mismatch("grad_y", m_axis_tdata[63:32], g.gy);
                if (m_axis_tdata[95:64] !== g.gz)
                    report_mismatch("grad_z", m_axis_tdata[95:64], g.gz);
                if (m_axis_tuser !== g.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(g.status));
            end
        end
    end

    task automatic drain();
        while (cell_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (grad_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // random stencil: target, a run of neighbors, sometimes noise and overflow
    task automatic queue_stencil();
        int n;
        logic [31:0] tx, ty, tz;
        tx = rand_word(); ty = rand_word(); tz = rand_word();
        if ($urandom_range(0, 3) != 0) begin
            tx = near_word(); ty = near_word(); tz = near_word();
        end
        cell_q.push_back(mk(ACT_TARGET, tx, ty, tz, rand_word(), 1'($urandom_range(0, 1))));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                cell_q.push_back(mk(ACT_NEIGHBOR, rand_word(), rand_word(), rand_word(),
                                    rand_word(), i == n - 1));
            else
                cell_q.push_back(mk(ACT_NEIGHBOR, tx + near_word(), ty + near_word(),
                                    tz + near_word(), $urandom, i == n - 1));
        end
    endtask

    initial begin
        int phase_idle[4] = '{0, 53, 0, 37};
        int phase_stall[4] = '{0, 0, 53, 37};
        i_clk = 0; i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0; s_axis_tlast = 0;
        m_axis_tready = 0;
        errors = 0; n_sent = 0; n_grads = 0; n_singular = 0; n_dropped = 0;
        send_idle = 0; recv_stall = 0; hold_send = 0;
        tgt_x = 0; tgt_y = 0; tgt_z = 0; tgt_v = 0;
        clear_sums();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;

        // solve before any target, with a single neighbor (singular)
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h0001_0000, 0, 0, 32'h0002_0000, 1'b1));
        // last on a set-target item is ignored
        cell_q.push_back(mk(ACT_TARGET, 0, 0, 0, 0, 1'b1));
        // axis-aligned stencil: clean gradient
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h0001_0000, 0, 0, 32'h0003_0000, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 0, 32'h0001_0000, 0, 32'hFFFE_0000, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 0, 0, 32'h0001_0000, 32'h0000_8000, 1'b1));
        // extremes: saturated offsets and accumulators, steep gradient
        cell_q.push_back(mk(ACT_TARGET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1'b1));
        // tiny offsets with a huge value jump: gradient saturates
        cell_q.push_back(mk(ACT_TARGET, 0, 0, 0, 32'h8000_0000, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h0000_0001, 0, 0, 32'h7FFF_FFFF, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 0, 32'h0000_0001, 0, 32'h7FFF_FFFF, 1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 0, 0, 32'h0000_0001, 0, 1'b1));
        // collinear neighbors: singular
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 5,
                            1'b0));
        cell_q.push_back(mk(ACT_NEIGHBOR, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 9,
                            1'b1));
        drain();

        // too many neighbors: count fills, the rest is dropped
        cell_q.push_back(mk(ACT_TARGET, 0, 0, 0, 0, 1'b0));
        for (int i = 0; i < MAX_NEIGHBORS + 3; i++)
            cell_q.push_back(mk(ACT_NEIGHBOR, near_word(), near_word(), near_word(),
                                $urandom, i == MAX_NEIGHBORS + 2));
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle = phase_idle[p];
            recv_stall = phase_stall[p];
            while (cell_q.size() < 125) queue_stencil();
            if (p == 2) begin
                // pause the sender until every gradient has come back
                while (cell_q.size() > 65 || s_axis_tvalid) @(posedge i_clk);
                hold_send = 1;
                while (grad_q.size() > 0) @(posedge i_clk);
                @(negedge i_clk) hold_send = 0;
            end
            drain();
        end
        send_idle = 0; recv_stall = 0;

        $display("covered %0d cells, %0d gradients (%0d singular, %0d with dropped neighbors)",
                 n_sent, n_grads, n_singular, n_dropped);
        $display("idle and stall phases 0/0, 53/0, 0/53 and 37/37 percent");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
